@@ rtl/fpa_pkg.sv @@
package fpa_pkg;

  // Defaults for the top-level parameters
  localparam int SLOTS_DEF     = 16;
  localparam int SIZE_BITS_DEF = 16;

  // Fixed field widths
  localparam int FRAG_W   = 20;
  localparam int RANK_W   = 4;
  localparam int POLICY_W = 2;
  localparam int REQ_W    = 2;

  // Request type codes
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd2;

  // Fit policy codes (the spare code behaves as first fit)
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  // Result kind codes
  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // latch request, rewind scan pointer, clear sums
    logic scan;        // step the ascending scan
    logic shift_init;  // point the descending move pass at the top of the table
    logic shift;       // step the descending move pass
    logic put;         // write the new slot at the insert position
    logic alloc_hit;   // shrink the hit slot, answer placed
    logic alloc_miss;  // flag the failure, answer not placed
    logic report;      // emit the report, empty the table
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_end;
    logic shift_end;
    logic full;
    logic sorted;
  } dp_sts_t;

endpackage

@@ rtl/fit_policy_partition_allocator.sv @@
// Partition allocator with first, best and worst fit. Issue a request by
// raising start while busy is low; the request is taken at that clock edge.
// Load requests fill a table of up to SLOTS partitions (a load into a full
// table is dropped silently); under best or worst fit each load is inserted
// in ascending or descending order of size, under first fit it is appended.
// An allocation request scans the table from slot 0 for the first slot with
// enough space, shrinks it and answers with placed and the slot position.
// A report request scans the table, returns total, external and internal
// fragmentation (all zero with all_fit low if any allocation failed since the
// last report) and empties the table. Answers and reports appear for exactly
// one cycle with result_valid high and cannot be held off by the receiver;
// loads give no result. The table lives in two single-port-write RAMs
// with registered reads, streamed one slot per cycle. A dropped load or an
// unknown request type leaves the block idle; a first-fit load writes its
// slot directly; an allocation scans up to the slot it lands in; one that
// finds no room, and a report, scan every slot in use; a sorted load scans
// to its insert position, then moves every slot above it up by one, and
// then writes the new slot. No new request is taken while busy is high.
// busy drops in the cycle the result is shown, so the next request can be
// taken right then. Write fit_policy through cfg_valid / cfg_data only while
// idle; cfg_ready follows !busy. The policy only affects where later loads go.
module fit_policy_partition_allocator #(
  parameter int SLOTS     = fpa_pkg::SLOTS_DEF,
  parameter int SIZE_BITS = fpa_pkg::SIZE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic [fpa_pkg::REQ_W-1:0]     req_type,
  input  logic [SIZE_BITS-1:0]          size_value,
  // policy register write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fpa_pkg::POLICY_W-1:0]  cfg_data,
  // result channel
  output logic                          result_valid,
  output logic                          result_kind,
  output logic                          placed,
  output logic [fpa_pkg::RANK_W-1:0]    slot_rank,
  output logic                          all_fit,
  output logic [fpa_pkg::FRAG_W-1:0]    total_frag,
  output logic [fpa_pkg::FRAG_W-1:0]    external_frag,
  output logic [fpa_pkg::FRAG_W-1:0]    internal_frag
);
  import fpa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  // Take policy writes only between requests
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Sequencer: decode the request, step scans and move passes, fire results
  fpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  // Table RAMs, scan pointers, sums and result registers
  fpa_dpath #(
    .SLOTS     (SLOTS),
    .SIZE_BITS (SIZE_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req_type),
    .size_value    (size_value),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .result_kind   (result_kind),
    .placed        (placed),
    .slot_rank     (slot_rank),
    .all_fit       (all_fit),
    .total_frag    (total_frag),
    .external_frag (external_frag),
    .internal_frag (internal_frag)
  );

`ifndef SYNTHESIS
  // Results never come back to back: each needs a fresh request and a scan
  a_result_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  // A result is shown only once the sequencer is back to idle
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while busy");

  // An allocation or report request always occupies the block
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == REQ_ALLOC || req_type == REQ_REPORT)) |=> busy)
    else $error("allocation or report request taken without going busy");
`endif

endmodule

@@ rtl/fpa_ram.sv @@
module fpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/fpa_ctrl.sv @@
module fpa_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fpa_pkg::REQ_W-1:0]  req_type,
  input  fpa_pkg::dp_sts_t           sts,
  output fpa_pkg::dp_cmd_t           cmd,
  output logic                       busy
);
  import fpa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_SCAN,
    ST_LD_SHIFT,
    ST_LD_PUT,
    ST_AL_SCAN,
    ST_RP_SCAN
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (req_type)
            REQ_LOAD: begin
              // drop loads into a full table
              if (!sts.full) begin
                state_next = sts.sorted ? ST_LD_SCAN : ST_LD_PUT;
              end
            end
            REQ_ALLOC:  state_next = ST_AL_SCAN;
            REQ_REPORT: state_next = ST_RP_SCAN;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_LD_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.scan_end) begin
          cmd.shift_init = 1'b1;
          state_next     = ST_LD_SHIFT;
        end
      end
      ST_LD_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_end) begin
          state_next = ST_LD_PUT;
        end
      end
      ST_LD_PUT: begin
        cmd.put    = 1'b1;
        state_next = ST_IDLE;
      end
      ST_AL_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          cmd.alloc_hit = 1'b1;
          state_next    = ST_IDLE;
        end else if (sts.scan_end) begin
          cmd.alloc_miss = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_RP_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          cmd.report = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

endmodule

@@ rtl/fpa_dpath.sv @@
module fpa_dpath #(
  parameter int SLOTS     = fpa_pkg::SLOTS_DEF,
  parameter int SIZE_BITS = fpa_pkg::SIZE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fpa_pkg::dp_cmd_t              cmd,
  output fpa_pkg::dp_sts_t              sts,
  input  logic [fpa_pkg::REQ_W-1:0]     req_type,
  input  logic [SIZE_BITS-1:0]          size_value,
  input  logic                          cfg_we,
  input  logic [fpa_pkg::POLICY_W-1:0]  cfg_data,
  output logic                          result_valid,
  output logic                          result_kind,
  output logic                          placed,
  output logic [fpa_pkg::RANK_W-1:0]    slot_rank,
  output logic                          all_fit,
  output logic [fpa_pkg::FRAG_W-1:0]    total_frag,
  output logic [fpa_pkg::FRAG_W-1:0]    external_frag,
  output logic [fpa_pkg::FRAG_W-1:0]    internal_frag
);
  import fpa_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic [POLICY_W-1:0]  fit_policy;
  logic [CW-1:0]        slot_count;
  logic                 any_failed;
  logic                 is_alloc;
  logic [SIZE_BITS-1:0] req_size;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        pos;
  logic [AW-1:0]        didx;
  logic                 dval;
  logic [FRAG_W-1:0]    tot;
  logic [FRAG_W-1:0]    ext;

  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [SIZE_BITS-1:0] orig_wdata;
  logic [SIZE_BITS-1:0] rem_wdata;
  logic                 orig_we;
  logic                 rem_we;
  logic [SIZE_BITS-1:0] orig_q;
  logic [SIZE_BITS-1:0] rem_q;
  logic                 sorted;
  logic                 goes_before;
  logic                 cond;

  fpa_ram #(.WIDTH(SIZE_BITS), .DEPTH(SLOTS)) u_orig_ram (
    .clk   (clk),
    .we    (orig_we),
    .waddr (wr_addr),
    .wdata (orig_wdata),
    .raddr (rd_addr),
    .rdata (orig_q)
  );

  fpa_ram #(.WIDTH(SIZE_BITS), .DEPTH(SLOTS)) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (wr_addr),
    .wdata (rem_wdata),
    .raddr (rd_addr),
    .rdata (rem_q)
  );

  assign sorted      = (fit_policy == POL_BEST) || (fit_policy == POL_WORST);
  assign goes_before = (fit_policy == POL_BEST) ? (orig_q <= req_size) : (orig_q >= req_size);
  assign cond        = is_alloc ? (req_size <= rem_q) : !goes_before;

  always_comb begin
    sts.hit       = dval && cond && cmd.scan;
    sts.scan_end  = !dval && (idx >= slot_count);
    sts.shift_end = !dval && (idx <= pos);
    sts.full      = (slot_count == CW'(SLOTS));
    sts.sorted    = sorted;
  end

  // Read pointer: ascending scan reads idx, the move pass reads the slot below idx
  assign rd_addr = cmd.shift ? AW'(idx - 1'b1) : idx[AW-1:0];

  always_comb begin
    orig_we    = 1'b0;
    rem_we     = 1'b0;
    wr_addr    = didx;
    orig_wdata = req_size;
    rem_wdata  = req_size;
    if (cmd.alloc_hit) begin
      rem_we    = 1'b1;
      rem_wdata = rem_q - req_size;
    end else if (cmd.shift && dval) begin
      orig_we    = 1'b1;
      rem_we     = 1'b1;
      wr_addr    = didx + AW'(1);
      orig_wdata = orig_q;
      rem_wdata  = rem_q;
    end else if (cmd.put) begin
      orig_we = 1'b1;
      rem_we  = 1'b1;
      wr_addr = pos[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy   <= POL_FIRST;
      slot_count   <= '0;
      any_failed   <= 1'b0;
      dval         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        fit_policy <= cfg_data;
      end

      if (cmd.accept) begin
        dval <= 1'b0;
      end else if (cmd.shift_init) begin
        dval <= 1'b0;
      end else if (cmd.scan) begin
        dval <= (idx < slot_count);
      end else if (cmd.shift) begin
        dval <= (idx > pos);
      end

      if (cmd.put) begin
        slot_count <= slot_count + 1'b1;
      end else if (cmd.report) begin
        slot_count <= '0;
      end

      if (cmd.alloc_miss) begin
        any_failed <= 1'b1;
      end else if (cmd.report) begin
        any_failed <= 1'b0;
      end

      result_valid <= cmd.alloc_hit || cmd.alloc_miss || cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_alloc <= (req_type == REQ_ALLOC);
      req_size <= size_value;
      idx      <= '0;
      pos      <= slot_count;
      tot      <= '0;
      ext      <= '0;
    end else if (cmd.shift_init) begin
      idx <= slot_count;
      if (dval && cond) begin
        pos <= CW'(didx);
      end
    end else if (cmd.scan) begin
      if (idx < slot_count) begin
        idx  <= idx + 1'b1;
        didx <= idx[AW-1:0];
      end
      if (dval) begin
        tot <= tot + FRAG_W'(rem_q);
        if (rem_q == orig_q) begin
          ext <= ext + FRAG_W'(rem_q);
        end
      end
    end else if (cmd.shift) begin
      if (idx > pos) begin
        idx  <= idx - 1'b1;
        didx <= AW'(idx - 1'b1);
      end
    end

    if (cmd.alloc_hit || cmd.alloc_miss) begin
      result_kind   <= KIND_ANSWER;
      placed        <= cmd.alloc_hit;
      slot_rank     <= cmd.alloc_hit ? RANK_W'(didx) : '0;
      all_fit       <= 1'b0;
      total_frag    <= '0;
      external_frag <= '0;
      internal_frag <= '0;
    end else if (cmd.report) begin
      result_kind   <= KIND_REPORT;
      placed        <= 1'b0;
      slot_rank     <= '0;
      all_fit       <= !any_failed;
      total_frag    <= any_failed ? '0 : tot;
      external_frag <= any_failed ? '0 : ext;
      internal_frag <= any_failed ? '0 : tot - ext;
    end
  end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fpa_pkg::*;

  // Spare codes the package leaves unnamed: the block ignores this request
  // type, and treats this policy value as first fit.
  localparam logic [REQ_W-1:0]    REQ_SPARE = 2'd3;
  localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;

  localparam int SLOTS     = SLOTS_DEF;
  localparam int SIZE_BITS = SIZE_BITS_DEF;

  // Longest request is a sorted load into a nearly full table; the wait
  // allows generously for it and for idle and drain waits.
  localparam int SETTLE_CYCLES = 64;
  localparam int ITEM_TARGET   = 1900;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic                kind;
    logic                placed;
    logic [RANK_W-1:0]   rank;
    logic                all_fit;
    logic [FRAG_W-1:0]   total;
    logic [FRAG_W-1:0]   ext_sum;
    logic [FRAG_W-1:0]   int_sum;
  } alloc_result_t;

  // One row of the directed table; when has_want is set the expected result
  // is the typed one instead of the predicted one.
  typedef struct packed {
    logic [REQ_W-1:0]     req;
    logic [SIZE_BITS-1:0] size;
    logic                 has_want;
    alloc_result_t        want;
  } stim_row_t;

  logic                  clk;
  logic                  rst        = 1'b1;
  logic                  start      = 1'b0;
  logic [REQ_W-1:0]      req_type   = REQ_LOAD;
  logic [SIZE_BITS-1:0]  size_value = '0;
  logic                  cfg_valid  = 1'b0;
  logic [POLICY_W-1:0]   cfg_data   = POL_FIRST;
  logic                  busy;
  logic                  cfg_ready;
  logic                  result_valid;
  logic                  result_kind;
  logic                  placed;
  logic [RANK_W-1:0]     slot_rank;
  logic                  all_fit;
  logic [FRAG_W-1:0]     total_frag;
  logic [FRAG_W-1:0]     external_frag;
  logic [FRAG_W-1:0]     internal_frag;

  // Shadow copy of the partition table and the policy register.
  logic [SIZE_BITS-1:0]  part_len  [SLOTS];
  logic [SIZE_BITS-1:0]  part_left [SLOTS];
  int unsigned           part_cnt;
  bit                    alloc_failed;
  logic [POLICY_W-1:0]   fit_mode;

  alloc_result_t         pending_results [$];
  alloc_result_t         oldest_result;
  stim_row_t             stim_table [$];

  int unsigned           mismatches  = 0;
  int unsigned           cycle_count = 0;
  int unsigned           items_sent;
  bit                    no_gaps;

  fit_policy_partition_allocator #(
    .SLOTS     (SLOTS),
    .SIZE_BITS (SIZE_BITS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .size_value    (size_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .result_kind   (result_kind),
    .placed        (placed),
    .slot_rank     (slot_rank),
    .all_fit       (all_fit),
    .total_frag    (total_frag),
    .external_frag (external_frag),
    .internal_frag (internal_frag)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs or a result never shows up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [FRAG_W-1:0] got,
                             input logic [FRAG_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Compute what one accepted request does to the shadow table and which
  // result, if any, it must produce.
  function automatic void predict_step(input logic [REQ_W-1:0] req,
                                       input logic [SIZE_BITS-1:0] sz,
                                       output bit has_result,
                                       output alloc_result_t res);
    int unsigned pos;
    int unsigned k;
    bit found;
    logic [FRAG_W-1:0] tot;
    logic [FRAG_W-1:0] ext;
    res = '0;
    has_result = 0;
    case (req)
      REQ_LOAD: begin
        // Drop loads into a full table; otherwise append, or insert after
        // every slot of equal size under the sorted policies.
        if (part_cnt < SLOTS) begin
          pos = part_cnt;
          if (fit_mode == POL_BEST || fit_mode == POL_WORST) begin
            pos = 0;
            while (pos < part_cnt &&
                   ((fit_mode == POL_BEST) ? (part_len[pos] <= sz)
                                           : (part_len[pos] >= sz)))
              pos++;
            for (k = part_cnt; k > pos; k--) begin
              part_len[k]  = part_len[k-1];
              part_left[k] = part_left[k-1];
            end
          end
          part_len[pos]  = sz;
          part_left[pos] = sz;
          part_cnt++;
        end
      end
      REQ_ALLOC: begin
        found = 0;
        for (k = 0; k < part_cnt; k++) begin
          if (!found && sz <= part_left[k]) begin
            part_left[k] = part_left[k] - sz;
            found = 1;
            res.rank = RANK_W'(k);
          end
        end
        if (!found)
          alloc_failed = 1;
        res.kind = KIND_ANSWER;
        res.placed = found;
        has_result = 1;
      end
      REQ_REPORT: begin
        tot = '0;
        ext = '0;
        if (!alloc_failed) begin
          for (k = 0; k < part_cnt; k++) begin
            tot = tot + part_left[k];
            if (part_left[k] == part_len[k])
              ext = ext + part_left[k];
          end
        end
        res.kind = KIND_REPORT;
        res.all_fit = !alloc_failed;
        res.total = tot;
        res.ext_sum = ext;
        res.int_sum = tot - ext;
        part_cnt = 0;
        alloc_failed = 0;
        has_result = 1;
      end
      default: ;
    endcase
  endfunction

  function automatic alloc_result_t mk_answer(input logic fit, input logic [RANK_W-1:0] rank);
    alloc_result_t r;
    r = '0;
    r.kind = KIND_ANSWER;
    r.placed = fit;
    r.rank = rank;
    return r;
  endfunction

  function automatic alloc_result_t mk_report(input logic ok, input logic [FRAG_W-1:0] tot,
                                              input logic [FRAG_W-1:0] ext,
                                              input logic [FRAG_W-1:0] intl);
    alloc_result_t r;
    r = '0;
    r.kind = KIND_REPORT;
    r.all_fit = ok;
    r.total = tot;
    r.ext_sum = ext;
    r.int_sum = intl;
    return r;
  endfunction

  task automatic add_row(input logic [REQ_W-1:0] req, input logic [SIZE_BITS-1:0] sz,
                         input logic has_want, input alloc_result_t want);
    stim_row_t row;
    row.req = req;
    row.size = sz;
    row.has_want = has_want;
    row.want = want;
    stim_table.push_back(row);
  endtask

  // Drive one request and hold it until the block takes it, then queue the
  // result it must produce. Leaves start high so back-to-back requests work.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [SIZE_BITS-1:0] sz,
                              input logic has_want, input alloc_result_t want);
    bit has_result;
    alloc_result_t pred;
    start <= 1'b1;
    req_type <= req;
    size_value <= sz;
    do @(posedge clk); while (busy);
    predict_step(req, sz, has_result, pred);
    if (has_result)
      pending_results.push_back(has_want ? want : pred);
    if (req != REQ_SPARE)
      items_sent++;
  endtask

  // Idle the request side for a while: mostly short gaps, now and then a
  // long one, and none at all while a burst group is running.
  task automatic idle_gap();
    int unsigned n;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 45)
      n = 0;
    else if (r < 90)
      n = $urandom_range(1, 3);
    else
      n = $urandom_range(8, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop start, wait for every outstanding result, then let a load that
  // gives no result finish its table move.
  task automatic settle_block();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_policy(input logic [POLICY_W-1:0] pol);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_data <= pol;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fit_mode = pol;
  endtask

  function automatic logic [SIZE_BITS-1:0] rand_size(input int unsigned scale);
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0)
      return '0;
    if (r == 1)
      return '1;
    if (r == 2)
      return SIZE_BITS'($urandom);
    return SIZE_BITS'($urandom_range(0, scale));
  endfunction

  // One well-formed session: loads mixed with allocations at a common size
  // scale, closed by a report most of the time. Without the report the table
  // carries over, so a later policy write lands on a populated table.
  task automatic run_group();
    int unsigned n_load;
    int unsigned n_alloc;
    int unsigned scale;
    int unsigned r;
    r = $urandom_range(0, 9);
    scale = (r < 5) ? 15 : (r < 8) ? 1023 : 65535;
    n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 20) : $urandom_range(0, 10);
    n_alloc = $urandom_range(0, 12);
    while (n_load + n_alloc > 0) begin
      r = $urandom_range(0, 49);
      if (r == 0)
        send_request(REQ_SPARE, SIZE_BITS'($urandom), 1'b0, '0);
      else if (r == 1)
        send_request(REQ_ALLOC, SIZE_BITS'($urandom), 1'b0, '0);
      else if (n_load > 0 && (n_alloc == 0 || $urandom_range(0, 2) != 0)) begin
        send_request(REQ_LOAD, rand_size(scale), 1'b0, '0);
        n_load--;
      end else begin
        send_request(REQ_ALLOC, rand_size(scale), 1'b0, '0);
        n_alloc--;
      end
      idle_gap();
    end
    if ($urandom_range(0, 6) != 0) begin
      send_request(REQ_REPORT, SIZE_BITS'($urandom), 1'b0, '0);
      idle_gap();
    end
  endtask

  // Compare each result against the oldest outstanding one.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_results.size() == 0)
        report_mismatch("result with nothing outstanding");
      else begin
        oldest_result = pending_results.pop_front();
        check_field("result_kind", FRAG_W'(result_kind), FRAG_W'(oldest_result.kind));
        check_field("placed", FRAG_W'(placed), FRAG_W'(oldest_result.placed));
        check_field("slot_rank", FRAG_W'(slot_rank), FRAG_W'(oldest_result.rank));
        check_field("all_fit", FRAG_W'(all_fit), FRAG_W'(oldest_result.all_fit));
        check_field("total_frag", total_frag, oldest_result.total);
        check_field("external_frag", external_frag, oldest_result.ext_sum);
        check_field("internal_frag", internal_frag, oldest_result.int_sum);
      end
    end
  end

  initial begin
    int i;
    int unsigned policy_writes;
    logic [POLICY_W-1:0] next_policy;

    items_sent = 0;
    no_gaps = 0;
    policy_writes = 0;
    part_cnt = 0;
    alloc_failed = 0;
    fit_mode = POL_FIRST;

    // Directed table. Start on an empty table: a zero-size allocation must
    // fail, the report after it reads all zero with all_fit low, and the
    // next report on the cleared table is clean.
    add_row(REQ_ALLOC, '0, 1'b1, mk_answer(1'b0, '0));
    add_row(REQ_REPORT, '1, 1'b1, mk_report(1'b0, '0, '0, '0));
    add_row(REQ_REPORT, '0, 1'b1, mk_report(1'b1, '0, '0, '0));
    add_row(REQ_SPARE, '1, 1'b0, '0);
    // Fill the table with the largest size, then overflow it by one.
    for (i = 0; i < SLOTS; i++)
      add_row(REQ_LOAD, '1, 1'b0, '0);
    add_row(REQ_LOAD, '0, 1'b0, '0);
    // A zero-size allocation lands in the first slot and leaves it unchanged.
    add_row(REQ_ALLOC, '0, 1'b1, mk_answer(1'b1, '0));
    add_row(REQ_REPORT, 16'h5a5a, 1'b1,
            mk_report(1'b1, FRAG_W'(SLOTS * 65535), FRAG_W'(SLOTS * 65535), '0));

    // Hold reset, then release it.
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      send_request(stim_table[i].req, stim_table[i].size,
                   stim_table[i].has_want, stim_table[i].want);
      idle_gap();
    end
    // Pause the sender until every directed result is back.
    settle_block();

    // Random sessions; step through every policy value first, then pick at
    // random between sessions.
    while (items_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      run_group();
      if ($urandom_range(0, 2) == 0) begin
        case (policy_writes)
          0: next_policy = POL_WORST;
          1: next_policy = POL_SPARE;
          2: next_policy = POL_BEST;
          3: next_policy = POL_FIRST;
          default: next_policy = POLICY_W'($urandom_range(0, 3));
        endcase
        write_policy(next_policy);
        policy_writes++;
      end
    end

    // Drain: wait for the last results, then a quiet stretch to catch strays.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fpa_pkg.sv
rtl/fpa_ram.sv
rtl/fpa_ctrl.sv
rtl/fpa_dpath.sv
rtl/fit_policy_partition_allocator.sv
verif/tb_top.sv
